### rtl/xsp_pkg.sv
`timescale 1ns / 1ps

package xsp_pkg;

  localparam int BLOCK_BYTES = 65536;
  localparam int OFF_W       = $clog2(BLOCK_BYTES);
  localparam int MAX_BLOCKS  = 1024;
  localparam int BLK_W       = $clog2(MAX_BLOCKS) + 1;
  localparam int MAX_LEVEL   = 10;
  localparam int MIN_LEVEL   = 2;
  localparam int LVL_W       = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LVL_W-1:0] LEVEL_RST = LVL_W'(2);
  localparam logic [31:0]      CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0]      CRC_INIT  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_DRAIN = 2'd2
  } kind_t;

  // one classified beat, front to back
  typedef struct packed {
    kind_t             kind;
    logic              first;    // first block of stripe: store data as is
    logic              last;     // last part: parity byte goes out
    logic              crc_end;  // closes the parity block
    logic              err;
    logic [LVL_W-1:0]  part;
    logic [7:0]        data;
    logic [OFF_W-1:0]  addr;
  } ent_t;

  function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/xor_stripe_parity_crc.sv
`timescale 1ns / 1ps
// Channel | Dir | Signals                      | Contents
// in      | in  | in_tvalid/tready/tdata/tuser | tdata: data_byte; tuser: cmd
// out     | out | out_tvalid/tready/tdata/tuser| one result per input beat
// cfg     | in  | cfg_valid/ready/data         | part count, 4 bits
//
// One input beat per cycle sustained while out_tready stays high; a result passes through the queue,
// the s1 stage and the output register. The 64K x 8 parity store has one read and one write port;
// the back end reads it as an entry enters s1 and writes a data beat's parity byte as s1 moves on.
// Reset (rst_n low, synchronous) clears all counters, flags and the CRC; the
// parity store is not cleared. A stall on out_tready fills the two-entry queue
// before in_tready drops.

module xor_stripe_parity_crc (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [3:0] part_index, [11:4] out_byte, [19:12] parity_byte,
                                  // [51:20] parity_crc, [52] overflow_error, [55:53] zero
  output logic [2:0]  out_tuser,  // [0] data_valid, [1] parity_valid, [2] crc_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  xsp_pkg::ent_t push_ent, pop_ent;
  logic          accept, q_valid, q_pop;

  assign accept = in_tvalid && in_tready;

  xsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .cmd       (in_tuser),
    .data_byte (in_tdata),
    .ent       (push_ent)
  );

  xsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_ent   (push_ent),
    .push_ready (in_tready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_ent    (pop_ent)
  );

  xsp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ent      (pop_ent),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### rtl/xsp_front.sv
`timescale 1ns / 1ps

module xsp_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [xsp_pkg::LVL_W-1:0]    cfg_data,
  input  logic                         accept,
  input  logic                         cmd,
  input  logic [7:0]                   data_byte,
  output xsp_pkg::ent_t                ent
);

  logic [xsp_pkg::LVL_W-1:0] lvl_cfg_r;
  logic [xsp_pkg::OFF_W-1:0] off_r, off_nxt;
  logic [xsp_pkg::LVL_W-1:0] stripe_r, stripe_nxt;
  logic [xsp_pkg::BLK_W-1:0] blocks_r, blocks_nxt;
  logic                      pend_r, pend_nxt;
  logic                      err_r, err_nxt;

  logic [xsp_pkg::LVL_W-1:0] level;
  logic                      last;
  logic                      at_end;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (lvl_cfg_r < xsp_pkg::LVL_W'(xsp_pkg::MIN_LEVEL)) begin
      level = xsp_pkg::LVL_W'(xsp_pkg::MIN_LEVEL);
    end else if (lvl_cfg_r > xsp_pkg::LVL_W'(xsp_pkg::MAX_LEVEL)) begin
      level = xsp_pkg::LVL_W'(xsp_pkg::MAX_LEVEL);
    end else begin
      level = lvl_cfg_r;
    end
  end

  assign last   = ({1'b0, stripe_r} + 5'd1) >= {1'b0, level};
  assign at_end = off_r == xsp_pkg::OFF_W'(xsp_pkg::BLOCK_BYTES - 1);

  always_comb begin
    off_nxt     = off_r;
    stripe_nxt  = stripe_r;
    blocks_nxt  = blocks_r;
    pend_nxt    = pend_r;
    err_nxt     = err_r;
    ent.kind    = xsp_pkg::KIND_NONE;
    ent.first   = stripe_r == '0;
    ent.last    = last;
    ent.crc_end = 1'b0;
    ent.part    = last ? (level - xsp_pkg::LVL_W'(1)) : stripe_r;
    ent.data    = data_byte;
    ent.addr    = off_r;
    if (!cmd) begin
      if (pend_r && off_r != '0) begin
        // drain in progress: data dropped
      end else if (blocks_r >= xsp_pkg::BLK_W'(xsp_pkg::MAX_BLOCKS)) begin
        err_nxt = 1'b1;
      end else begin
        ent.kind = xsp_pkg::KIND_DATA;
        pend_nxt = at_end && !last;
        if (at_end) begin
          off_nxt    = '0;
          blocks_nxt = blocks_r + xsp_pkg::BLK_W'(1);
          if (last) begin
            ent.crc_end = 1'b1;
            stripe_nxt  = '0;
          end else begin
            stripe_nxt = stripe_r + xsp_pkg::LVL_W'(1);
          end
        end else begin
          off_nxt = off_r + xsp_pkg::OFF_W'(1);
        end
      end
    end else if (pend_r) begin
      ent.kind = xsp_pkg::KIND_DRAIN;
      if (at_end) begin
        ent.crc_end = 1'b1;
        stripe_nxt  = '0;
        pend_nxt    = 1'b0;
        off_nxt     = '0;
      end else begin
        off_nxt = off_r + xsp_pkg::OFF_W'(1);
      end
    end
    ent.err = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_cfg_r <= xsp_pkg::LEVEL_RST;
      off_r     <= '0;
      stripe_r  <= '0;
      blocks_r  <= '0;
      pend_r    <= 1'b0;
      err_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        lvl_cfg_r <= cfg_data;
      end
      if (accept) begin
        off_r    <= off_nxt;
        stripe_r <= stripe_nxt;
        blocks_r <= blocks_nxt;
        pend_r   <= pend_nxt;
        err_r    <= err_nxt;
      end
    end
  end

  a_stripe_range: assert property (@(posedge clk) disable iff (!rst_n)
    stripe_r < xsp_pkg::LVL_W'(xsp_pkg::MAX_LEVEL))
    else $error("stripe position out of range");

  a_pend_mid_stripe: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> stripe_r != '0)
    else $error("partial parity pending at stripe start");

  a_block_limit: assert property (@(posedge clk) disable iff (!rst_n)
    blocks_r <= xsp_pkg::BLK_W'(xsp_pkg::MAX_BLOCKS))
    else $error("block count past limit");

endmodule

### rtl/xsp_queue.sv
`timescale 1ns / 1ps

module xsp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  xsp_pkg::ent_t push_ent,
  output logic          push_ready,
  input  logic          pop,
  output logic          pop_valid,
  output xsp_pkg::ent_t pop_ent
);

  xsp_pkg::ent_t              ent_r [xsp_pkg::QUEUE_DEPTH];
  logic [xsp_pkg::QPTR_W-1:0] wr_r, rd_r;
  logic [xsp_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign push_ready = cnt_r != xsp_pkg::QCNT_W'(xsp_pkg::QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_ent    = ent_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + xsp_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - xsp_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + xsp_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_r <= rd_r + xsp_pkg::QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_ready || pop))
    else $error("push into full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("pop from empty queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == xsp_pkg::QCNT_W'(xsp_pkg::QUEUE_DEPTH)) |-> wr_r == rd_r)
    else $error("queue pointers disagree with count");

endmodule

### rtl/xsp_back.sv
`timescale 1ns / 1ps

module xsp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  xsp_pkg::ent_t q_ent,
  output logic          q_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [55:0]   out_tdata,
  output logic [2:0]    out_tuser
);

  logic [7:0] mem [xsp_pkg::BLOCK_BYTES];

  xsp_pkg::ent_t s1_r;
  logic          s1_v_r;
  logic [7:0]    rd_r;
  logic          s1_go;

  logic [31:0]   crc_r;
  logic [31:0]   crc_fed;
  logic [7:0]    par;
  logic          is_data, is_drain, pv;

  logic          out_v_r;
  logic [55:0]   tdata_r;
  logic [2:0]    tuser_r;

  assign s1_go = s1_v_r && (!out_v_r || out_tready);
  assign q_pop = q_valid && (!s1_v_r || s1_go);

  assign is_data  = s1_r.kind == xsp_pkg::KIND_DATA;
  assign is_drain = s1_r.kind == xsp_pkg::KIND_DRAIN;
  assign par      = (is_data && s1_r.first) ? s1_r.data
                  : (is_data ? (rd_r ^ s1_r.data) : rd_r);
  assign pv       = is_drain || (is_data && s1_r.last);
  assign crc_fed  = xsp_pkg::crc_feed(crc_r, par);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_r <= mem[q_ent.addr];
      s1_r <= q_ent;
    end
    if (s1_go && is_data) begin
      mem[s1_r.addr] <= par;
    end
  end

  // tdata: part_index, out_byte, parity_byte, parity_crc, overflow_error
  // tuser: data_valid, parity_valid, crc_valid
  always_ff @(posedge clk) begin
    if (s1_go) begin
      tdata_r[3:0]   <= is_data ? s1_r.part : '0;
      tdata_r[11:4]  <= is_data ? s1_r.data : '0;
      tdata_r[19:12] <= pv ? par : '0;
      tdata_r[51:20] <= (pv && s1_r.crc_end) ? ~crc_fed : '0;
      tdata_r[52]    <= s1_r.err;
      tdata_r[55:53] <= '0;
      tuser_r        <= {pv && s1_r.crc_end, pv, is_data};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      crc_r   <= xsp_pkg::CRC_INIT;
    end else begin
      if (q_pop) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (s1_go && pv) begin
        crc_r <= s1_r.crc_end ? xsp_pkg::CRC_INIT : crc_fed;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = tdata_r;
  assign out_tuser  = tuser_r;

  a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && pv && s1_r.crc_end) |=> crc_r == xsp_pkg::CRC_INIT)
    else $error("crc not restarted after parity block");

  a_crc_needs_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && tuser_r[2] |-> tuser_r[1])
    else $error("crc beat without parity byte");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !out_v_r) |-> s1_go)
    else $error("stage stalled with empty output");

endmodule
